// File: rtl/sacp_pkg.sv
// Shared types and constants for the calibrated sensor averaging block.
// Used by sacp_div, the top level sensor_average_calibrated_percent and its checker.
`timescale 1ns / 1ps

package sacp_pkg;

    localparam int CHANNELS_DEF  = 3;
    localparam int SAMPLES_DEF   = 10;
    localparam int CAL_SETS      = 3;

    localparam int CH_W          = 2;
    localparam int ADC_W         = 12;
    localparam int SUM_W         = 16;
    localparam int CNT_W         = 4;
    localparam int PCT_W         = 7;
    localparam int CFG_IDX_W     = 3;

    // dividend carries (dry - level) * 100, up to 4095 * 100
    localparam int DVD_W         = 19;
    localparam int STEP_W        = 5;

    localparam logic [ADC_W-1:0] DRY_RESET     = 12'd4095;
    localparam logic [ADC_W-1:0] WET_RESET     = 12'd275;
    localparam logic [PCT_W-1:0] FULL_PERCENT  = 7'd100;
    localparam logic [PCT_W-1:0] DRY_THRESHOLD = 7'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WET_2  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL,
        ST_PCT,
        ST_OUT
    } sacp_state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [ADC_W-1:0] divisor;
    } sacp_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } sacp_div_rsp_t;

endpackage

// File: rtl/sacp_div.sv
// Restoring divider, one quotient bit per cycle, shared by the averaging and scaling steps.
// Depends on sacp_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module sacp_div
    import sacp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  sacp_div_req_t req,
    output sacp_div_rsp_t rsp
);

    logic [DVD_W-1:0]  work_reg;
    logic [ADC_W-1:0]  rem_reg;
    logic [ADC_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ADC_W:0]    rem_shift;
    logic              fits;
    logic [ADC_W:0]    rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, work_reg[DVD_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit into the remainder, subtract where it fits
            work_reg <= {work_reg[DVD_W-2:0], fits};
            rem_reg  <= fits ? rem_sub[ADC_W-1:0] : rem_shift[ADC_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

// File: rtl/sensor_average_calibrated_percent.sv
// Top level: per-channel sample accumulation, averaging, clamping and percent scaling.
// Depends on sacp_pkg and the shared divider sacp_div.
`timescale 1ns / 1ps
//
//  beat     handshake            payload
//  input    in_valid / in_ready  channel, sample
//  result   out_valid/out_ready  out_channel, average, percent, is_dry, calib_error
//  config   cfg_we (no wait)     cfg_index, cfg_data
//
// A sample that completes no block is taken while in_ready stays high.
// A sample that completes a block holds in_ready low through two divider
// passes (19 quotient bits each, then the done strobe), one multiply and one
// output step; a bad calibration skips the second pass.
// The result register holds while out_ready is low; a further block waits for it.
// Reset clears sums, counts and control, and loads the default calibration.

module sensor_average_calibrated_percent
    import sacp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int SAMPLES  = SAMPLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CH_W-1:0]      channel,
    input  logic [ADC_W-1:0]     sample,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CH_W-1:0]      out_channel,
    output logic [ADC_W-1:0]     average,
    output logic [PCT_W-1:0]     percent,
    output logic                 is_dry,
    output logic                 calib_error,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADC_W-1:0]     cfg_data
);

    localparam int ACT_CH = (CHANNELS < CAL_SETS) ? CHANNELS : CAL_SETS;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES % 16);
    localparam logic [ADC_W-1:0] SAMPLES_DIV = ADC_W'(SAMPLES);

    // configuration
    logic             enable_reg;
    logic [ADC_W-1:0] dry_reg [CAL_SETS];
    logic [ADC_W-1:0] wet_reg [CAL_SETS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            for (int i = 0; i < CAL_SETS; i++)
            begin
                dry_reg[i] <= DRY_RESET;
                wet_reg[i] <= WET_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_DRY_0:  dry_reg[0] <= cfg_data;
                REG_WET_0:  wet_reg[0] <= cfg_data;
                REG_DRY_1:  dry_reg[1] <= cfg_data;
                REG_WET_1:  wet_reg[1] <= cfg_data;
                REG_DRY_2:  dry_reg[2] <= cfg_data;
                REG_WET_2:  wet_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer
    sacp_state_t   state_reg, state_next;
    sacp_div_req_t div_req;
    sacp_div_rsp_t div_rsp;

    logic             accept;
    logic             ch_ok;
    logic [SUM_W-1:0] sum_sel;
    logic [CNT_W-1:0] cnt_sel;
    logic [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0] cnt_new;
    logic             block_done;

    logic [SUM_W-1:0] sum_reg [ACT_CH];
    logic [CNT_W-1:0] cnt_reg [ACT_CH];

    logic [CH_W-1:0]  ch_reg;
    logic [ADC_W-1:0] avg_reg;
    logic [ADC_W-1:0] clamp_reg;
    logic             err_reg;
    logic [PCT_W-1:0] pct_reg;

    logic [ADC_W-1:0] dry_sel;
    logic [ADC_W-1:0] wet_sel;
    logic [ADC_W-1:0] avg_q;
    logic [ADC_W-1:0] clamp_q;
    logic [ADC_W-1:0] span;
    logic [DVD_W-1:0] scaled;

    logic             out_free;
    logic             out_valid_reg;
    logic [CH_W-1:0]  out_channel_reg;
    logic [ADC_W-1:0] average_reg;
    logic [PCT_W-1:0] percent_reg;
    logic             is_dry_reg;
    logic             calib_error_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign ch_ok    = (int'(channel) < ACT_CH);

    always_comb
    begin
        sum_sel = '0;
        cnt_sel = '0;
        for (int i = 0; i < ACT_CH; i++)
        begin
            if (channel == CH_W'(i))
            begin
                sum_sel = sum_reg[i];
                cnt_sel = cnt_reg[i];
            end
        end
        sum_new    = sum_sel + SUM_W'(sample);
        cnt_new    = cnt_sel + 1'b1;
        block_done = accept && enable_reg && ch_ok && (cnt_new == LAST_COUNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACT_CH; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (accept && enable_reg && ch_ok)
        begin
            for (int i = 0; i < ACT_CH; i++)
            begin
                if (channel == CH_W'(i))
                begin
                    // restart the channel once its block is complete
                    sum_reg[i] <= block_done ? '0 : sum_new;
                    cnt_reg[i] <= block_done ? '0 : cnt_new;
                end
            end
        end
    end

    always_comb
    begin
        dry_sel = DRY_RESET;
        wet_sel = WET_RESET;
        unique case (ch_reg)
            2'd0:    begin dry_sel = dry_reg[0]; wet_sel = wet_reg[0]; end
            2'd1:    begin dry_sel = dry_reg[1]; wet_sel = wet_reg[1]; end
            2'd2:    begin dry_sel = dry_reg[2]; wet_sel = wet_reg[2]; end
            default: ;
        endcase
        avg_q = div_rsp.quotient[ADC_W-1:0];
        if (avg_q < wet_sel)
            clamp_q = wet_sel;
        else if (avg_q > dry_sel)
            clamp_q = dry_sel;
        else
            clamp_q = avg_q;
        span   = dry_sel - wet_sel;
        scaled = DVD_W'(dry_sel - clamp_reg) * DVD_W'(FULL_PERCENT);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_req    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (block_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(sum_new);
                    div_req.divisor  = SAMPLES_DIV;
                    state_next       = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (div_rsp.done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (err_reg)
                    state_next = ST_OUT;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = scaled;
                    div_req.divisor  = span;
                    state_next       = ST_PCT;
                end
            end
            ST_PCT:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (block_done)
            ch_reg <= channel;
        if (state_reg == ST_AVG && div_rsp.done)
        begin
            avg_reg   <= avg_q;
            clamp_reg <= clamp_q;
            err_reg   <= (wet_sel >= dry_sel);
            pct_reg   <= '0;
        end
        if (state_reg == ST_PCT && div_rsp.done)
            pct_reg <= div_rsp.quotient[PCT_W-1:0];
    end

    sacp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_channel_reg <= ch_reg;
            average_reg     <= avg_reg;
            percent_reg     <= pct_reg;
            is_dry_reg      <= (pct_reg < DRY_THRESHOLD);
            calib_error_reg <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign average     = average_reg;
    assign percent     = percent_reg;
    assign is_dry      = is_dry_reg;
    assign calib_error = calib_error_reg;

endmodule

// File: rtl/sacp_checker.sv
// Port-level checks for sensor_average_calibrated_percent, attached by bind.
// Depends on sacp_pkg for widths and thresholds.
`timescale 1ns / 1ps

module sacp_checker
    import sacp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CH_W-1:0]  out_channel,
    input logic [ADC_W-1:0] average,
    input logic [PCT_W-1:0] percent,
    input logic             is_dry,
    input logic             calib_error
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_channel)
            && $stable(average) && $stable(percent) && $stable(is_dry)
            && $stable(calib_error))
        else $error("result beat changed while stalled");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> percent <= FULL_PERCENT)
        else $error("percent above full scale");

    a_dry_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_dry == (percent < DRY_THRESHOLD))
        else $error("dry flag disagrees with percent");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calib_error |-> percent == '0 && is_dry)
        else $error("bad calibration must report zero percent");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_channel) < CAL_SETS)
        else $error("result for a channel without calibration");

endmodule

bind sensor_average_calibrated_percent sacp_checker u_sacp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .average     (average),
    .percent     (percent),
    .is_dry      (is_dry),
    .calib_error (calib_error)
);

// File: sim/sacp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for sensor_average_calibrated_percent: follows register writes, folds accepted
// sample beats into per-channel sums and checks every result beat against its prediction.
// Depends on sacp_pkg.

module sacp_result_checker
    import sacp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int SAMPLES  = SAMPLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CH_W-1:0]      channel,
    input  logic [ADC_W-1:0]     sample,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CH_W-1:0]      out_channel,
    input  logic [ADC_W-1:0]     average,
    input  logic [PCT_W-1:0]     percent,
    input  logic                 is_dry,
    input  logic                 calib_error,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADC_W-1:0]     cfg_data,

    output int                   fail_count,
    output int                   pending
);

    typedef struct {
        logic [CH_W-1:0]  ch;
        logic [ADC_W-1:0] avg;
        logic [PCT_W-1:0] pct;
        logic             dry;
        logic             err;
    } moisture_t;

    moisture_t        awaited [$];
    logic             enabled;
    logic [ADC_W-1:0] dry_lvl [CAL_SETS];
    logic [ADC_W-1:0] wet_lvl [CAL_SETS];
    logic [SUM_W-1:0] acc_sum [CHANNELS];
    logic [CNT_W-1:0] acc_cnt [CHANNELS];
    int               mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] result mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // clamp the mean into the window and scale it, inverted, to 0..100; error if wet >= dry
    function automatic moisture_t moisture_result(input logic [CH_W-1:0] ch,
                                                  input logic [ADC_W-1:0] avg);
        moisture_t   r;
        int unsigned dry_v;
        int unsigned wet_v;
        int unsigned lvl;
        dry_v = dry_lvl[ch];
        wet_v = wet_lvl[ch];
        r.ch  = ch;
        r.avg = avg;
        if (wet_v >= dry_v)
        begin
            r.err = 1'b1;
            r.pct = '0;
        end
        else
        begin
            r.err = 1'b0;
            lvl   = avg;
            if (lvl < wet_v)
                lvl = wet_v;
            else if (lvl > dry_v)
                lvl = dry_v;
            r.pct = PCT_W'(((dry_v - lvl) * FULL_PERCENT) / (dry_v - wet_v));
        end
        r.dry = (r.pct < DRY_THRESHOLD);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        moisture_t        want;
        logic [SUM_W-1:0] nsum;
        logic [CNT_W-1:0] ncnt;
        if (!rst_n)
        begin
            enabled = 1'b1;
            for (int i = 0; i < CAL_SETS; i++)
            begin
                dry_lvl[i] = DRY_RESET;
                wet_lvl[i] = WET_RESET;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                acc_sum[i] = '0;
                acc_cnt[i] = '0;
            end
            awaited.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                    report_mismatch("result beat with nothing awaited, channel", out_channel, -1);
                else
                begin
                    want = awaited.pop_front();
                    if (out_channel !== want.ch)
                        report_mismatch("out_channel", out_channel, want.ch);
                    if (average !== want.avg)
                        report_mismatch("average", average, want.avg);
                    if (percent !== want.pct)
                        report_mismatch("percent", percent, want.pct);
                    if (is_dry !== want.dry)
                        report_mismatch("is_dry", is_dry, want.dry);
                    if (calib_error !== want.err)
                        report_mismatch("calib_error", calib_error, want.err);
                end
            end

            // drop beats while disabled or on a channel without a calibration pair
            if (in_valid && in_ready && enabled && channel < CHANNELS && channel < CAL_SETS)
            begin
                nsum = acc_sum[channel] + sample;
                ncnt = acc_cnt[channel] + 1'b1;
                if (ncnt == CNT_W'(SAMPLES % 16))
                begin
                    awaited.push_back(moisture_result(channel, ADC_W'(nsum / SAMPLES)));
                    nsum = '0;
                    ncnt = '0;
                end
                acc_sum[channel] = nsum;
                acc_cnt[channel] = ncnt;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE: enabled    = cfg_data[0];
                    REG_DRY_0:  dry_lvl[0] = cfg_data;
                    REG_WET_0:  wet_lvl[0] = cfg_data;
                    REG_DRY_1:  dry_lvl[1] = cfg_data;
                    REG_WET_1:  wet_lvl[1] = cfg_data;
                    REG_DRY_2:  dry_lvl[2] = cfg_data;
                    REG_WET_2:  wet_lvl[2] = cfg_data;
                    default:    ;
                endcase
            end

            fail_count <= mismatches;
            pending    <= awaited.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for sensor_average_calibrated_percent: drives samples, results back-pressure
// and register writes through several calibration settings; sacp_result_checker does the checks.
// Depends on sacp_pkg, sacp_result_checker and the block's RTL.

module tb;
    import sacp_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 220;

    // register index past the end of the list
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CH_W-1:0]      channel;
    logic [ADC_W-1:0]     sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [CH_W-1:0]      out_channel;
    logic [ADC_W-1:0]     average;
    logic [PCT_W-1:0]     percent;
    logic                 is_dry;
    logic                 calib_error;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADC_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_req_n;
    int cycles;
    int win_dry [CAL_SETS];
    int win_wet [CAL_SETS];

    sensor_average_calibrated_percent dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .average     (average),
        .percent     (percent),
        .is_dry      (is_dry),
        .calib_error (calib_error),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    sacp_result_checker moisture_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .average     (average),
        .percent     (percent),
        .is_dry      (is_dry),
        .calib_error (calib_error),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // result side: random back-pressure, plus a long hold-off whenever one is requested
    initial
    begin
        int done_n;
        done_n    = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req_n != done_n)
            begin
                done_n++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one sample beat and hold it until accepted; returns at the accepting edge
    task automatic send_beat(input logic [CH_W-1:0] ch, input logic [ADC_W-1:0] value);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering, wait for every awaited result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADC_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_window(input int ch, input int dry_v, input int wet_v);
        write_reg(REG_DRY_0 + CFG_IDX_W'(2 * ch), ADC_W'(dry_v));
        write_reg(REG_WET_0 + CFG_IDX_W'(2 * ch), ADC_W'(wet_v));
        win_dry[ch] = dry_v;
        win_wet[ch] = wet_v;
    endtask

    task automatic randomize_windows();
        int d;
        int w;
        int t;
        for (int ch = 0; ch < CAL_SETS; ch++)
        begin
            d = $urandom_range(4095);
            w = $urandom_range(4095);
            // mostly well-formed windows, now and then an inverted one
            if (w > d && $urandom_range(9) != 0)
            begin
                t = d;
                d = w;
                w = t;
            end
            set_window(ch, d, w);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_level(input int ch);
        int r;
        int lo;
        int hi;
        r  = $urandom_range(99);
        lo = (win_wet[ch] < win_dry[ch]) ? win_wet[ch] : win_dry[ch];
        hi = (win_wet[ch] < win_dry[ch]) ? win_dry[ch] : win_wet[ch];
        lo = (lo > 40) ? lo - 40 : 0;
        hi = (hi < 4055) ? hi + 40 : 4095;
        if (r < 15)
            return $urandom_range(1) * 4095;
        else if (r < 40)
            return $urandom_range(4095);
        return $urandom_range(hi, lo);
    endfunction

    // mostly whole blocks of readings around one level on one channel, the rest loose beats
    task automatic run_random(input int items);
        int sent;
        int ch;
        int level;
        int spread;
        int v;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(99) < 80)
            begin
                ch     = $urandom_range(CAL_SETS - 1);
                level  = pick_level(ch);
                spread = ($urandom_range(3) == 0) ? 0 : 8;
                for (int k = 0; k < SAMPLES_DEF; k++)
                begin
                    v = level + $urandom_range(2 * spread) - spread;
                    v = (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
                    send_beat(CH_W'(ch), ADC_W'(v));
                    sent++;
                end
            end
            else
            begin
                ch = $urandom_range(3);
                send_beat(CH_W'(ch), ADC_W'($urandom_range(4095)));
                if (ch < CAL_SETS)
                    sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        channel     = '0;
        sample      = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req_n  = 0;
        tx_idle_pct = 15;
        rx_idle_pct = 47;
        for (int ch = 0; ch < CAL_SETS; ch++)
        begin
            win_dry[ch] = DRY_RESET;
            win_wet[ch] = WET_RESET;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default calibration: full dry on channel 0, full wet on channel 1
        for (int k = 0; k < SAMPLES_DEF; k++)
        begin
            send_beat(2'd0, 12'hFFF);
            send_beat(2'd1, 12'h000);
            if (k == 4)
                send_beat(2'd3, 12'hA5C);
        end
        send_beat(2'd2, 12'h000);
        run_random(PHASE_ITEMS);
        settle();

        // widest window, wet equal to dry, and wet above dry
        write_reg(REG_ENABLE, 12'h001);
        set_window(0, 4095, 0);
        set_window(1, 2000, 2000);
        set_window(2, 0, 4095);
        cfg_we <= 1'b0;
        hold_req_n <= hold_req_n + 1;
        run_random(PHASE_ITEMS);
        settle();

        tx_idle_pct = 47;
        rx_idle_pct = 15;
        // windows one step wide; index past the list must do nothing
        set_window(0, 1, 0);
        set_window(1, 4095, 4094);
        set_window(2, 2048, 2047);
        write_reg(REG_UNUSED, ADC_W'($urandom_range(4095)));
        cfg_we <= 1'b0;
        run_random(PHASE_ITEMS);
        settle();

        // disabled: beats are dropped and partial sums are kept
        write_reg(REG_ENABLE, 12'hFFE);
        cfg_we <= 1'b0;
        for (int k = 0; k < 40; k++)
            send_beat(CH_W'($urandom_range(3)), ADC_W'($urandom_range(4095)));
        settle();
        write_reg(REG_ENABLE, {11'($urandom_range(2047)), 1'b1});
        randomize_windows();
        run_random(PHASE_ITEMS);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        randomize_windows();
        hold_req_n <= hold_req_n + 1;
        run_random(PHASE_ITEMS);
        settle();

        randomize_windows();
        run_random(PHASE_ITEMS);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sensor_average_calibrated_percent.f
rtl/sacp_pkg.sv
rtl/sacp_div.sv
rtl/sensor_average_calibrated_percent.sv
rtl/sacp_checker.sv
sim/sacp_result_checker.sv
sim/tb.sv
